@@ design/b64sd_pkg.sv @@
// Package for the base64 stream decoder: result type, status codes and decode helpers.
`timescale 1ns / 1ps
`default_nettype none

package b64sd_pkg;

	localparam int CountWidth = 16;
	localparam int TotalWidth = 16;
	localparam int ResDepth   = 3;

	localparam logic [1:0] StatData = 2'd0;
	localparam logic [1:0] StatOk   = 2'd1;
	localparam logic [1:0] StatFail = 2'd2;

	localparam logic [7:0] ChCr  = 8'h0D;
	localparam logic [7:0] ChLf  = 8'h0A;
	localparam logic [7:0] ChPad = 8'h3D;

	typedef struct packed {
		logic                  is_last;
		logic [TotalWidth-1:0] byte_total;
		logic [1:0]            status;
		logic [7:0]            data_byte;
	} res_t;

	// bit 6 set when the character is in the alphabet, bits 5:0 the sextet
	function automatic logic [6:0] sextet_of(input logic [7:0] ch);
		logic [6:0] r;
		r = '0;
		case (ch) inside
			[8'h41:8'h5A]: r = {1'b1, 6'(ch - 8'h41)};
			[8'h61:8'h7A]: r = {1'b1, 6'(ch - 8'h47)};
			[8'h30:8'h39]: r = {1'b1, 6'(ch + 8'h04)};
			8'h2B:         r = {1'b1, 6'd62};
			8'h2F:         r = {1'b1, 6'd63};
			default:       r = '0;
		endcase
		return r;
	endfunction

	function automatic logic [CountWidth-1:0] sat_inc(input logic [CountWidth-1:0] c);
		return (&c) ? c : c + CountWidth'(1);
	endfunction

	function automatic logic [TotalWidth-1:0] shown(input logic [CountWidth-1:0] c);
		logic [CountWidth+TotalWidth-1:0] wide;
		logic [CountWidth+TotalWidth-1:0] lim;
		wide = (CountWidth+TotalWidth)'(c);
		lim  = (CountWidth+TotalWidth)'({TotalWidth{1'b1}});
		return (wide > lim) ? {TotalWidth{1'b1}} : TotalWidth'(wide);
	endfunction

endpackage

`default_nettype wire

@@ design/base64_stream_decoder_top.sv @@
// Base64 stream decoder: character decode, group assembly and result queue.
//
//  channel  dir  tdata                          tuser/tlast
//  s_*      in   symbol[7:0]                    tuser = end_of_text
//  m_*      out  data_byte[7:0] total[23:8]     tuser = status, tlast = is_last
//
// A character is decoded in the cycle it is accepted; its bytes enter a
// three-entry result queue and leave one per cycle while m_tready is high.
// Items that give no result are taken while the queue drains; an item
// with results waits until the queue is empty or holds its last entry
// being taken. Reset clears group state, error and count.
`timescale 1ns / 1ps
`default_nettype none

module base64_stream_decoder_top import b64sd_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,   // symbol[7:0]
	input  wire logic        s_tuser,   // end_of_text
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [23:0]      m_tdata,   // data_byte[7:0], byte_total[23:8]
	output logic [1:0]       m_tuser,   // status[1:0]
	output logic             m_tlast
);

	logic [17:0]           accum_q;
	logic [1:0]            pos_q;
	logic [1:0]            pad_q;
	logic                  err_q;
	logic [CountWidth-1:0] ctr_q;

	res_t                  res_q [ResDepth];
	logic [1:0]            cnt_q;

	logic [17:0]           accum_d;
	logic [1:0]            pos_d;
	logic [1:0]            pad_d;
	logic                  err_d;
	logic [CountWidth-1:0] ctr_d;
	logic [23:0]           word;
	logic [1:0]            nb;
	logic                  fin;
	logic [1:0]            nres;
	logic [CountWidth-1:0] cinc [ResDepth+1];
	res_t                  res_d [ResDepth];
	logic                  accept;
	logic                  take;

	always_comb begin
		logic [6:0] sx;
		logic [5:0] v;
		logic [2:0] pads;
		logic       ok;
		accum_d = accum_q;
		pos_d   = pos_q;
		pad_d   = pad_q;
		err_d   = err_q;
		word    = '0;
		nb      = '0;
		fin     = 1'b0;
		sx      = sextet_of(s_tdata);
		v       = '0;
		pads    = '0;
		ok      = 1'b0;
		if (s_tuser) begin
			fin = 1'b1;
			if (!err_q) begin
				if (pos_q == 2'd1) begin
					err_d = 1'b1;
				end else if (pos_q == 2'd2) begin
					word = {accum_q[11:0], 12'd0};
					pads = 3'(pad_q) + 3'd2;
				end else if (pos_q == 2'd3) begin
					word = {accum_q, 6'd0};
					pads = 3'(pad_q) + 3'd1;
				end
				if (pos_q[1])
					nb = (pads >= 3'd3) ? 2'd0 : 2'(3'd3 - pads);
			end
			accum_d = '0;
			pos_d   = '0;
			pad_d   = '0;
		end else if (!err_q && !(pos_q == 2'd0 && (s_tdata == ChCr || s_tdata == ChLf))) begin
			if (s_tdata == ChPad) begin
				if (!pos_q[1]) begin
					err_d = 1'b1;
				end else begin
					pad_d = pad_q + 2'd1;
					ok    = 1'b1;
				end
			end else if (!sx[6] || pad_q != 2'd0) begin
				err_d = 1'b1;
			end else begin
				v  = sx[5:0];
				ok = 1'b1;
			end
			if (ok) begin
				if (pos_q == 2'd3) begin
					word    = {accum_q, v};
					nb      = 2'(2'd3 - pad_d);
					accum_d = '0;
					pos_d   = '0;
					pad_d   = '0;
				end else begin
					accum_d = {accum_q[11:0], v};
					pos_d   = pos_q + 2'd1;
				end
			end
		end
	end

	always_comb begin
		cinc[0] = ctr_q;
		for (int i = 1; i <= ResDepth; i++)
			cinc[i] = sat_inc(cinc[i-1]);
		ctr_d = fin ? '0 : cinc[nb];
		nres  = nb + 2'(fin);
		for (int i = 0; i < ResDepth; i++) begin
			res_d[i] = '0;
			if (2'(i) < nb) begin
				res_d[i].data_byte  = word[23-8*i -: 8];
				res_d[i].status     = StatData;
				res_d[i].byte_total = shown(cinc[i+1]);
			end else if (2'(i) == nb && fin) begin
				res_d[i].status     = err_d ? StatFail : StatOk;
				res_d[i].byte_total = shown(cinc[nb]);
				res_d[i].is_last    = 1'b1;
			end
		end
	end

	assign take     = m_tvalid && m_tready;
	assign s_tready = (cnt_q == 2'd0) || (cnt_q == 2'd1 && m_tready) || (nres == 2'd0);
	assign accept   = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			accum_q <= '0;
			pos_q   <= '0;
			pad_q   <= '0;
			err_q   <= 1'b0;
			ctr_q   <= '0;
			cnt_q   <= '0;
		end else begin
			if (accept) begin
				accum_q <= accum_d;
				pos_q   <= pos_d;
				pad_q   <= pad_d;
				err_q   <= fin ? 1'b0 : err_d;
				ctr_q   <= ctr_d;
			end
			if (accept && nres != 2'd0)
				cnt_q <= nres;
			else if (take)
				cnt_q <= cnt_q - 2'd1;
		end
	end

	// queue payload: load a whole burst, otherwise shift toward the head
	always_ff @(posedge clk) begin
		if (accept && nres != 2'd0) begin
			for (int i = 0; i < ResDepth; i++)
				res_q[i] <= res_d[i];
		end else if (take) begin
			for (int i = 0; i < ResDepth-1; i++)
				res_q[i] <= res_q[i+1];
		end
	end

	assign m_tvalid = (cnt_q != 2'd0);
	assign m_tdata  = {res_q[0].byte_total, res_q[0].data_byte};
	assign m_tuser  = res_q[0].status;
	assign m_tlast  = res_q[0].is_last;

`ifndef ASSERT_OFF
	a_load_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && nres != 2'd0) |-> (cnt_q == 2'd0 || (cnt_q == 2'd1 && m_tready)))
		else $error("result burst loaded over pending results");

	a_eot_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && s_tuser) |=> m_tvalid)
		else $error("end of text produced no final status");

	a_last_is_status: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tlast) |-> (m_tuser == StatOk || m_tuser == StatFail))
		else $error("final result carries data status");

	a_data_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser == StatData) |-> !m_tlast)
		else $error("data byte marked last");

	a_clear_after_eot: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && s_tuser) |=> (pos_q == 2'd0 && !err_q && ctr_q == '0))
		else $error("group state not cleared after end of text");
`endif

endmodule

`default_nettype wire
